/* src/pcpa_pkg.sv */
// pcpa_pkg: shared types and constants of the per-cpu page allocator
// request/response payload structs, adder request, sequencer states, codes
// no dependencies
package pcpa_pkg;

   localparam int ADDR_W    = 32;
   localparam int REQ_CPU_W = 3;
   localparam int CSR_IDX_W = 4;
   localparam int SUM_W     = ADDR_W + 1;

   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_REGION_START = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_STOP  = 4'd1;

   localparam logic [ADDR_W-1:0] REGION_START_RESET = 32'd0;
   localparam logic [ADDR_W-1:0] REGION_STOP_RESET  = 32'd2281701376;

   typedef struct packed {
      logic                 cmd;
      logic [REQ_CPU_W-1:0] cpu_index;
      logic [ADDR_W-1:0]    page_addr_in;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] page_addr_out;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] op_a;
      logic [SUM_W-1:0] op_b;
      logic             sub;
   } alu_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_FREE,
      ST_SCAN,
      ST_SPUSH,
      ST_POP,
      ST_POP_WB
   } fsm_state_type;

endpackage

/* src/pcpa_alu.sv */
// pcpa_alu: shared 33-bit add/subtract unit of the allocator sequencer
// used for page base rounding, free offset and allocated address
// depends on pcpa_pkg
module pcpa_alu
   import pcpa_pkg::*;
(
   input  alu_req_type      alu_req,
   output logic [SUM_W-1:0] alu_sum
);

   always_comb begin
      if (alu_req.sub) begin
         alu_sum = alu_req.op_a - alu_req.op_b;
      end else begin
         alu_sum = alu_req.op_a + alu_req.op_b;
      end
   end

endmodule

/* src/pcpa_link_mem.sv */
// pcpa_link_mem: next-link store, one write and one registered read per cycle
// entry holds a valid bit over a page index
// no dependencies
module pcpa_link_mem #(
   parameter int DEPTH  = 32768,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/per_cpu_page_free_list_allocator_core.sv */
// per_cpu_page_free_list_allocator_core: top level of the per-cpu page allocator
// sequencer, list heads and config registers; uses pcpa_alu and pcpa_link_mem
// depends on pcpa_pkg
//
// usage:
//   a request is taken at a rising edge with start high and busy low; busy stays
//   high until the response strobe. req_data.cmd selects free or allocate,
//   req_data.cpu_index picks the list (taken modulo NUM_CPUS).
//   one response per request: rsp_valid is high for exactly one cycle with
//   rsp_data; the receiver cannot stall, so it must take it in that cycle.
//   busy falls in the same cycle as the strobe.
//   steps from the accepting edge to the strobe: free goes through base and
//   free, allocate from a nonempty list through base, pop and pop writeback.
//   an allocate from an empty list first steals: the scan visits the cpu
//   indices in order, skipping itself and empty lists, and moves pages one at
//   a time (link store read then write) until STEAL_BATCH pages have moved or
//   the scan ends; with nothing found anywhere it answers empty. the link
//   store has one read and one write port with registered read data, so pops
//   and moves read first. PAGE_BYTES must be a power of two; it is not checked.
//   csr writes (index 0 region_start, 1 region_stop) are taken every cycle and
//   are meant to happen while busy is low.
//   reset: all lists empty, registers at defaults, no clearing pass; the link
//   store is only read at entries that were pushed.
module per_cpu_page_free_list_allocator_core
   import pcpa_pkg::*;
#(
   parameter int NUM_CPUS    = 8,
   parameter int MAX_PAGES   = 32768,
   parameter int STEAL_BATCH = 64,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam int CPU_W      = $clog2(NUM_CPUS);
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int LINK_W     = IDX_W + 1;
   localparam int OTHER_W    = $clog2(NUM_CPUS + 1);
   localparam int LEFT_W     = $clog2(STEAL_BATCH + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CPU_VALS   = 2 ** REQ_CPU_W;
   localparam logic [SUM_W-1:0] PAGE_MASK = ~(SUM_W'(PAGE_BYTES) - SUM_W'(1));

   fsm_state_type      state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CPU_W-1:0]   cpu_ff, cpu_in;
   logic [SUM_W-1:0]   base_ff, base_in;
   logic [OTHER_W-1:0] other_ff, other_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [IDX_W-1:0]   head_idx_ff [NUM_CPUS];
   logic [IDX_W-1:0]   head_idx_in [NUM_CPUS];
   logic               head_vld_ff [NUM_CPUS];
   logic               head_vld_in [NUM_CPUS];
   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [ADDR_W-1:0]  stop_ff, stop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   alu_req_type        alu_req;
   logic [SUM_W-1:0]   alu_sum;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [LINK_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [LINK_W-1:0]  mem_rd_data;

   logic [CPU_W-1:0]   cpu_lut [CPU_VALS];
   logic [CPU_W-1:0]   other_sel;
   logic [IDX_W-1:0]   cur_idx, oth_idx, rd_idx;
   logic               cur_vld, oth_vld, rd_vld;
   logic               scan_done, scan_skip;
   logic [SUM_W-1:0]   free_page;
   logic               free_bad;

   for (genvar g = 0; g < CPU_VALS; g++) begin : g_cpu_lut
      assign cpu_lut[g] = CPU_W'(g % NUM_CPUS);
   end

   pcpa_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   pcpa_link_mem #(
      .DEPTH  (MAX_PAGES),
      .WIDTH  (LINK_W),
      .ADDR_W (IDX_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign other_sel = other_ff[CPU_W-1:0];
   assign cur_idx   = head_idx_ff[cpu_ff];
   assign cur_vld   = head_vld_ff[cpu_ff];
   assign oth_idx   = head_idx_ff[other_sel];
   assign oth_vld   = head_vld_ff[other_sel];
   assign rd_idx    = mem_rd_data[IDX_W-1:0];
   assign rd_vld    = mem_rd_data[IDX_W];
   assign scan_done = (other_ff == OTHER_W'(NUM_CPUS));
   assign scan_skip = (other_sel == cpu_ff) || !oth_vld;

   // offset from page base, valid when the address checks pass
   assign free_page = alu_sum >> PAGE_SHIFT;
   assign free_bad  = (req_ff.page_addr_in[PAGE_SHIFT-1:0] != '0) ||
                      (req_ff.page_addr_in < start_ff) ||
                      (req_ff.page_addr_in >= stop_ff) ||
                      (free_page >= SUM_W'(MAX_PAGES));

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (req_ff.cmd == CMD_FREE) begin
               state_in = ST_FREE;
            end else if (cur_vld) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FREE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_POP;
            end else if (!scan_skip) begin
               state_in = ST_SPUSH;
            end
         end
         ST_SPUSH: begin
            if (left_ff == LEFT_W'(1)) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_POP: begin
            if (cur_vld) begin
               state_in = ST_POP_WB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_WB: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // shared adder operands
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         ST_BASE: begin
            alu_req.op_a = {1'b0, start_ff};
            alu_req.op_b = SUM_W'(PAGE_BYTES - 1);
         end
         ST_FREE: begin
            alu_req.op_a = {1'b0, req_ff.page_addr_in};
            alu_req.op_b = base_ff;
            alu_req.sub  = 1'b1;
         end
         ST_POP_WB: begin
            alu_req.op_a = base_ff;
            alu_req.op_b = SUM_W'(cur_idx) << PAGE_SHIFT;
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   // datapath control
   always_comb begin
      req_in       = req_ff;
      cpu_in       = cpu_ff;
      base_in      = base_ff;
      other_in     = other_ff;
      left_in      = left_ff;
      head_idx_in  = head_idx_ff;
      head_vld_in  = head_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_idx;
      mem_wr_data  = {cur_vld, cur_idx};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = cur_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               cpu_in = cpu_lut[req_data.cpu_index];
            end
         end
         ST_BASE: begin
            base_in      = alu_sum & PAGE_MASK;
            other_in     = '0;
            left_in      = LEFT_W'(STEAL_BATCH);
         end
         ST_FREE: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.page_addr_out = '0;
            if (free_bad) begin
               rsp_data_in.status = STATUS_BAD_ADDR;
            end else begin
               rsp_data_in.status  = STATUS_OK;
               mem_wr_en           = 1'b1;
               mem_wr_addr         = free_page[IDX_W-1:0];
               head_idx_in[cpu_ff] = free_page[IDX_W-1:0];
               head_vld_in[cpu_ff] = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               if (scan_skip) begin
                  other_in = other_ff + OTHER_W'(1);
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = oth_idx;
               end
            end
         end
         ST_SPUSH: begin
            // pop the other list head, push it onto the requester
            head_idx_in[other_sel] = rd_idx;
            head_vld_in[other_sel] = rd_vld;
            mem_wr_en              = 1'b1;
            mem_wr_addr            = oth_idx;
            head_idx_in[cpu_ff]    = oth_idx;
            head_vld_in[cpu_ff]    = 1'b1;
            left_in                = left_ff - LEFT_W'(1);
         end
         ST_POP: begin
            if (cur_vld) begin
               mem_rd_en = 1'b1;
            end else begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.page_addr_out = '0;
               rsp_data_in.status        = STATUS_EMPTY;
            end
         end
         ST_POP_WB: begin
            head_idx_in[cpu_ff]       = rd_idx;
            head_vld_in[cpu_ff]       = rd_vld;
            rsp_valid_in              = 1'b1;
            rsp_data_in.page_addr_out = alu_sum[ADDR_W-1:0];
            rsp_data_in.status        = STATUS_OK;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // register writes
   always_comb begin
      start_in = start_ff;
      stop_in  = stop_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_REGION_START: start_in = csr_wdata;
            REG_REGION_STOP:  stop_in  = csr_wdata;
            default:          start_in = start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= REGION_START_RESET;
         stop_ff      <= REGION_STOP_RESET;
         for (int i = 0; i < NUM_CPUS; i++) begin
            head_vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         head_vld_ff  <= head_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cpu_ff      <= cpu_in;
      base_ff     <= base_in;
      other_ff    <= other_in;
      left_ff     <= left_in;
      head_idx_ff <= head_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // response strobe ends the request
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_steal_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPUSH) |-> (oth_vld && (other_sel != cpu_ff) && (left_ff != '0)))
      else $error("steal from empty list, self, or past batch");

   a_bad_only_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_BAD_ADDR)) |-> (req_ff.cmd == CMD_FREE))
      else $error("invalid address status on allocate");

endmodule

/* tb/pcpa_alloc_checker.sv */
`timescale 1ns / 100ps
// pcpa_alloc_checker: watches the request, response and csr channels of the page allocator,
// keeps its own per-cpu free lists and compares every response in order
// depends on pcpa_pkg
module pcpa_alloc_checker
   import pcpa_pkg::*;
#(
   parameter int NUM_CPUS    = 8,
   parameter int MAX_PAGES   = 32768,
   parameter int STEAL_BATCH = 64,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   input  logic                 busy,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);

   localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   logic [ADDR_W-1:0]     region_lo;
   logic [ADDR_W-1:0]     region_hi;
   logic [PAGE_IDX_W-1:0] head_page [NUM_CPUS];
   logic                  head_ok   [NUM_CPUS];
   logic [PAGE_IDX_W-1:0] link_page [MAX_PAGES];
   logic                  link_ok   [MAX_PAGES];
   rsp_type               awaited_rsp [$];
   int                    fault_count = 0;

   assign mismatches = fault_count;

   function automatic void list_push(int cpu, logic [PAGE_IDX_W-1:0] pg);
      link_page[pg] = head_page[cpu];
      link_ok[pg]   = head_ok[cpu];
      head_page[cpu] = pg;
      head_ok[cpu]   = 1'b1;
   endfunction

   function automatic logic [PAGE_IDX_W-1:0] list_pop(int cpu);
      logic [PAGE_IDX_W-1:0] pg;
      pg = head_page[cpu];
      head_page[cpu] = link_page[pg];
      head_ok[cpu]   = link_ok[pg];
      return pg;
   endfunction

   function automatic rsp_type page_outcome(req_type r);
      rsp_type               res;
      int                    cpu;
      int                    quota;
      logic [SUM_W-1:0]      base;
      logic [SUM_W-1:0]      idx;
      logic [PAGE_IDX_W-1:0] pg;
      res = '0;
      res.status = STATUS_OK;
      cpu = int'(r.cpu_index) % NUM_CPUS;
      // first page boundary at or above region start
      base = ({1'b0, region_lo} + SUM_W'(PAGE_BYTES - 1)) & ~SUM_W'(PAGE_BYTES - 1);
      if (r.cmd == CMD_FREE) begin
         if (r.page_addr_in[PAGE_SHIFT-1:0] != '0 || r.page_addr_in < region_lo ||
             r.page_addr_in >= region_hi) begin
            res.status = STATUS_BAD_ADDR;
         end else begin
            idx = ({1'b0, r.page_addr_in} - base) >> PAGE_SHIFT;
            if (idx >= SUM_W'(MAX_PAGES)) res.status = STATUS_BAD_ADDR;
            else list_push(cpu, idx[PAGE_IDX_W-1:0]);
         end
      end else begin
         // empty list: refill from the other cpus in index order
         if (!head_ok[cpu]) begin
            quota = STEAL_BATCH;
            for (int other = 0; other < NUM_CPUS && quota != 0; other++) begin
               if (other != cpu) begin
                  while (head_ok[other] && quota != 0) begin
                     list_push(cpu, list_pop(other));
                     quota--;
                  end
               end
            end
         end
         if (head_ok[cpu]) begin
            pg = list_pop(cpu);
            res.page_addr_out = ADDR_W'(base + (SUM_W'(pg) << PAGE_SHIFT));
         end else begin
            res.status = STATUS_EMPTY;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         region_lo = REGION_START_RESET;
         region_hi = REGION_STOP_RESET;
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_page[c] = '0;
            head_ok[c]   = 1'b0;
         end
         for (int p = 0; p < MAX_PAGES; p++) begin
            link_page[p] = '0;
            link_ok[p]   = 1'b0;
         end
         awaited_rsp.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $error("response with no request pending: page_addr_out %h, status %0d",
                      rsp_data.page_addr_out, rsp_data.status);
               fault_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.page_addr_out !== want.page_addr_out) begin
                  $error("page_addr_out: expected %h, actual %h",
                         want.page_addr_out, rsp_data.page_addr_out);
                  fault_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  fault_count++;
               end
            end
         end
         if (start && !busy) awaited_rsp.push_back(page_outcome(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REGION_START: region_lo = csr_wdata;
               REG_REGION_STOP:  region_hi = csr_wdata;
               default: ;
            endcase
         end
         outstanding <= awaited_rsp.size();
      end
   end

endmodule

/* tb/per_cpu_page_free_list_allocator_core_tb.sv */
`timescale 1ns / 100ps
// per_cpu_page_free_list_allocator_core_tb: drives free and allocate requests and region
// settings into the allocator core and reports the verdict
// depends on pcpa_pkg, pcpa_alloc_checker and per_cpu_page_free_list_allocator_core
module per_cpu_page_free_list_allocator_core_tb;
   import pcpa_pkg::*;

   localparam int NUM_CPUS         = 8;
   localparam int MAX_PAGES        = 32768;
   localparam int STEAL_BATCH      = 64;
   localparam int PAGE_BYTES       = 4096;
   localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);
   localparam int NUM_PHASES       = 7;
   localparam int RANDOM_PER_PHASE = 278;
   localparam int DRAIN_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT   = 4000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   req_type              req_data  = '0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_wdata = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_ready;
   int                   mismatches;
   int                   outstanding;
   int                   quiet_cycles = 0;
   logic [ADDR_W-1:0]    region_lo = REGION_START_RESET;
   logic [ADDR_W-1:0]    region_hi = REGION_STOP_RESET;
   logic [ADDR_W-1:0]    phase_lo [NUM_PHASES];
   logic [ADDR_W-1:0]    phase_hi [NUM_PHASES];

   always #4 clock = ~clock;

   per_cpu_page_free_list_allocator_core #(
      .NUM_CPUS(NUM_CPUS),
      .MAX_PAGES(MAX_PAGES),
      .STEAL_BATCH(STEAL_BATCH),
      .PAGE_BYTES(PAGE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pcpa_alloc_checker #(
      .NUM_CPUS(NUM_CPUS),
      .MAX_PAGES(MAX_PAGES),
      .STEAL_BATCH(STEAL_BATCH),
      .PAGE_BYTES(PAGE_BYTES)
   ) alloc_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("per_cpu_page_free_list_allocator_core_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock iff !busy);
   endtask

   task automatic send_fields(logic cmd, int cpu, logic [ADDR_W-1:0] addr);
      req_type r;
      r.cmd          = cmd;
      r.cpu_index    = REQ_CPU_W'(cpu);
      r.page_addr_in = addr;
      send_request(r);
   endtask

   task automatic pause_sender(int unsigned n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_REGION_START;
      csr_wdata <= lo;
      @(posedge clock iff csr_ready);
      @(negedge clock);
      csr_index <= REG_REGION_STOP;
      csr_wdata <= hi;
      @(posedge clock iff csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      region_lo = lo;
      region_hi = hi;
   endtask

   function automatic logic [ADDR_W-1:0] pick_free_addr();
      logic [SUM_W-1:0]  base;
      logic [ADDR_W-1:0] addr;
      int unsigned       sel;
      base = ({1'b0, region_lo} + SUM_W'(PAGE_BYTES - 1)) & ~SUM_W'(PAGE_BYTES - 1);
      sel  = $urandom_range(0, 99);
      if (sel < 68) begin
         addr = ADDR_W'(base + (SUM_W'($urandom_range(0, 47)) << PAGE_SHIFT));
      end else if (sel < 74) begin
         addr = ADDR_W'(base + (SUM_W'($urandom_range(0, MAX_PAGES - 1)) << PAGE_SHIFT));
      end else if (sel < 78) begin
         // around the end of the page store
         addr = ADDR_W'(base + (SUM_W'($urandom_range(MAX_PAGES - 2, MAX_PAGES + 1))
                                << PAGE_SHIFT));
      end else if (sel < 85) begin
         addr = ADDR_W'(base + (SUM_W'($urandom_range(0, 47)) << PAGE_SHIFT)) |
                ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
      end else if (sel < 91) begin
         // around region stop
         addr = (region_hi & ~ADDR_W'(PAGE_BYTES - 1)) + ADDR_W'(PAGE_BYTES) -
                (ADDR_W'($urandom_range(0, 2)) << PAGE_SHIFT);
      end else if (sel < 95) begin
         // around region start
         addr = (region_lo & ~ADDR_W'(PAGE_BYTES - 1)) -
                (ADDR_W'($urandom_range(0, 1)) << PAGE_SHIFT);
      end else begin
         addr = $urandom();
      end
      return addr;
   endfunction

   task automatic run_random(int unsigned count);
      int unsigned sent;
      int unsigned burst;
      int unsigned free_pct;
      int unsigned fav;
      int unsigned gap;
      req_type     r;
      sent = 0;
      while (sent < count) begin
         burst    = $urandom_range(1, 24);
         free_pct = ($urandom_range(0, 1) == 0) ? 75 : 30;
         fav      = $urandom_range(0, NUM_CPUS - 1);
         for (int unsigned n = 0; n < burst && sent < count; n++) begin
            r.cmd = ($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC;
            r.cpu_index = REQ_CPU_W'(($urandom_range(0, 9) < 6) ? fav :
                                     $urandom_range(0, NUM_CPUS - 1));
            r.page_addr_in = (r.cmd == CMD_FREE) ? pick_free_addr() : ADDR_W'($urandom());
            send_request(r);
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) pause_sender(gap);
      end
      pause_sender(1);
   endtask

   initial begin
      phase_lo[0] = 32'h0000_1234;  phase_hi[0] = 32'h0010_0000;
      phase_lo[1] = 32'h0000_0000;  phase_hi[1] = 32'hFFFF_FFFF;
      phase_lo[2] = 32'hFFFF_FFFF;  phase_hi[2] = 32'hFFFF_FFFF;
      phase_lo[3] = 32'hFFFF_0000;  phase_hi[3] = 32'h0000_0000;
      phase_lo[4] = 32'h8000_0000;  phase_hi[4] = 32'h8004_0000;
      phase_lo[5] = $urandom();     phase_hi[5] = $urandom();
      phase_lo[6] = REGION_START_RESET;
      phase_hi[6] = REGION_STOP_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default region, all lists empty
      send_fields(CMD_ALLOC, 0, 32'h0000_0000);
      send_fields(CMD_ALLOC, 7, 32'hFFFF_FFFF);
      send_fields(CMD_FREE,  0, 32'h0000_0000);
      send_fields(CMD_FREE,  0, 32'h0000_1000);
      send_fields(CMD_FREE,  7, 32'h07FF_F000);
      send_fields(CMD_FREE,  7, 32'h0800_0000);
      send_fields(CMD_FREE,  1, 32'h0000_0800);
      send_fields(CMD_FREE,  2, 32'h8800_0000);
      send_fields(CMD_FREE,  3, 32'hFFFF_F000);
      send_fields(CMD_FREE,  4, 32'hFFFF_FFFF);
      send_fields(CMD_FREE,  5, 32'h87FF_F000);
      send_fields(CMD_ALLOC, 0, 32'h0000_0000);
      send_fields(CMD_ALLOC, 0, 32'h0000_0000);
      send_fields(CMD_ALLOC, 1, 32'h0000_0000);
      send_fields(CMD_FREE,  6, 32'h0000_2000);
      // same page twice closes a loop in the list
      send_fields(CMD_FREE,  6, 32'h0000_2000);
      send_fields(CMD_ALLOC, 2, 32'h0000_0000);
      send_fields(CMD_ALLOC, 2, 32'h0000_0000);
      send_fields(CMD_ALLOC, 6, 32'h0000_0000);
      send_fields(CMD_ALLOC, 5, 32'hFFFF_FFFF);
      pause_sender(1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         @(posedge clock iff (outstanding == 0 && !busy));
         write_region(phase_lo[p], phase_hi[p]);
         run_random(RANDOM_PER_PHASE);
      end

      @(posedge clock iff (outstanding == 0 && !busy));
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("per_cpu_page_free_list_allocator_core_tb: done, clean");
      end else begin
         $display("per_cpu_page_free_list_allocator_core_tb: done, errors");
      end
      $finish;
   end

endmodule
